[src/tx_ring_buffer_overflow_marker_defines.svh]
// assertion macros for the transmit ring buffer block
// used by the top level only; define NO_ASSERTIONS to leave them out
`ifndef TX_RING_BUFFER_OVERFLOW_MARKER_DEFINES_SVH
`define TX_RING_BUFFER_OVERFLOW_MARKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TXRBOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TXRBOM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TXRBOM_ASSERT(lbl, prop, msg)
`define TXRBOM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/txrbom_pkg.sv]
// shared types, constants and helpers for the transmit ring buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package txrbom_pkg;

  // ring geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DATA_W      = 8;
  localparam int FILL_W      = 6;

  // overflow marker "!--overflow--!"
  localparam int MARKER_LEN = 14;
  localparam int MIDX_W     = $clog2(MARKER_LEN);
  localparam logic [DATA_W-1:0] MARKER_TEXT [MARKER_LEN] = '{
    8'h21, 8'h2D, 8'h2D, 8'h6F, 8'h76, 8'h65, 8'h72,
    8'h66, 8'h6C, 8'h6F, 8'h77, 8'h2D, 8'h2D, 8'h21
  };

  // bytes pending straight after an overflow
  localparam int MARK_FILL = (MARKER_LEN < QUEUE_DEPTH - 1) ? MARKER_LEN : QUEUE_DEPTH - 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t        LAST_SLOT = ptr_t'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_FIN
  } state_t;

  // one result beat
  typedef struct packed {
    logic              tx_valid;
    logic [DATA_W-1:0] tx_byte;
    logic              irq_enable;
    logic              overflow;
    logic [FILL_W-1:0] fill_level;
  } result_t;

  // access request towards the queue store
  typedef struct packed {
    logic              wr_en;
    ptr_t              wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    ptr_t              rd_addr;
  } ram_req_t;

  // ring pointer advance with wrap
  function automatic ptr_t next_slot(input ptr_t p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // pending bytes between read and write pointer
  function automatic ptr_t ring_level(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] wrapped;
    wrapped = {1'b0, wp} + DEPTH_EXT - {1'b0, rp};
    return (wp >= rp) ? wp - rp : wrapped[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/txrbom_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module txrbom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/txrbom_ctrl.sv]
// ring pointer control and overflow marker sequencer
// depends on txrbom_pkg; drives the queue store ram through ram_req_t
`timescale 1ns / 1ps
`default_nettype none

module txrbom_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       command,
  input  wire logic [txrbom_pkg::DATA_W-1:0] data_byte,
  output txrbom_pkg::ram_req_t            ram_req,
  input  wire logic [txrbom_pkg::DATA_W-1:0] ram_rd_data,
  output logic                            res_valid,
  output txrbom_pkg::result_t             res,
  input  wire logic                       res_take
);

  import txrbom_pkg::*;

  state_t            state, state_next;
  ptr_t              wp, wp_next;
  ptr_t              rp, rp_next;
  logic              irq, irq_next;
  logic              txv, txv_next;
  logic              ovf, ovf_next;
  logic [MIDX_W-1:0] midx, midx_next;
  logic              full;
  logic              empty;

  // state and pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      rp    <= '0;
      irq   <= 1'b0;
      txv   <= 1'b0;
      ovf   <= 1'b0;
      midx  <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      irq   <= irq_next;
      txv   <= txv_next;
      ovf   <= ovf_next;
      midx  <= midx_next;
    end
  end

  assign full  = (next_slot(wp) == rp);
  assign empty = (wp == rp);

  // next state, ram accesses and pointer updates
  always_comb begin
    state_next      = state;
    wp_next         = wp;
    rp_next         = rp;
    irq_next        = irq;
    txv_next        = txv;
    ovf_next        = ovf;
    midx_next       = midx;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = wp;
    ram_req.wr_data = data_byte;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rp;
    in_ready        = 1'b0;
    res_valid       = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_SEND) begin
            irq_next = 1'b1;
            txv_next = 1'b0;
            if (full) begin
              // flush pending bytes and queue the marker instead
              wp_next    = rp;
              midx_next  = '0;
              ovf_next   = 1'b1;
              state_next = ST_MARK;
            end else begin
              ram_req.wr_en = 1'b1;
              wp_next       = next_slot(wp);
              ovf_next      = 1'b0;
              state_next    = ST_FIN;
            end
          end else begin
            ovf_next = 1'b0;
            if (!empty) begin
              ram_req.rd_en = 1'b1;
              rp_next       = next_slot(rp);
              txv_next      = 1'b1;
            end else begin
              irq_next = 1'b0;
              txv_next = 1'b0;
            end
            state_next = ST_FIN;
          end
        end
      end

      ST_MARK: begin
        // one marker character per cycle; a full ring overwrites in place
        ram_req.wr_en   = 1'b1;
        ram_req.wr_data = MARKER_TEXT[midx];
        if (!full) begin
          wp_next = next_slot(wp);
        end
        midx_next = midx + 1'b1;
        if (midx == MIDX_W'(MARKER_LEN - 1)) begin
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result of the item just finished; read data holds while rd_en is low
  always_comb begin
    res.tx_valid   = txv;
    res.tx_byte    = txv ? ram_rd_data : '0;
    res.irq_enable = irq;
    res.overflow   = ovf;
    res.fill_level = FILL_W'(ring_level(wp, rp));
  end

endmodule

`default_nettype wire

[src/tx_ring_buffer_overflow_marker.sv]
// Transmit ring buffer with overflow marker, top level.
// A send or a tick is taken in the idle state; its result waits in the finish state until
// the output register takes it. A send that finds the ring full first passes through the
// marker state (14 marker writes, one per cycle). No new item is taken until the result
// has left the finish state, so an overflow holds the input during the marker writes.
// Reset: pointers, interrupt enable and handshakes clear; the queue store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "tx_ring_buffer_overflow_marker_defines.svh"

module tx_ring_buffer_overflow_marker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [7:0] tx_byte, [8] irq_enable, [9] overflow,
                                      // [15:10] fill_level
  output logic             m_tuser    // [0] tx_valid
);

  import txrbom_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rd_data;
  logic              res_valid;
  result_t           res;
  logic              res_take;
  logic              out_valid;
  result_t           out_res;

  // queue store
  txrbom_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // pointer control and marker sequencer
  txrbom_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (s_tuser),
    .data_byte   (s_tdata),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // output register, refilled as the previous beat leaves
  assign res_take = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.fill_level, out_res.overflow, out_res.irq_enable,
                     out_res.tx_byte};
  assign m_tuser  = out_res.tx_valid;

  // checks
  `TXRBOM_ASSERT(a_no_accept_while_finishing, s_tready |-> !res_valid, "input taken while a result is pending")
  `TXRBOM_ASSERT(a_result_holds, res_valid && !res_take |=> res_valid && $stable(res), "pending result changed before it was taken")
  `TXRBOM_ASSERT(a_overflow_level, out_valid && out_res.overflow |-> out_res.fill_level == FILL_W'(MARK_FILL) && out_res.irq_enable && !out_res.tx_valid, "overflow beat with wrong level or flags")
  `TXRBOM_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result beat shown straight after reset")

endmodule

`default_nettype wire

[tb/sv/tb_tx_ring_buffer_overflow_marker.sv]
// self-checking testbench for the transmit ring buffer with overflow marker
// depends on txrbom_pkg and the tx_ring_buffer_overflow_marker top level
// drives send and tick beats, predicts every result beat and compares field by field
`timescale 1ns / 1ps

module tb_tx_ring_buffer_overflow_marker;
  import txrbom_pkg::*;

  localparam int    ITEM_TOTAL     = 1750;
  localparam int    QUIET_TAIL     = 200;
  localparam int    RX_HOLD_CYCLES = 150;
  localparam int    CYCLE_LIMIT    = 400000;
  localparam int    SETTLE_CYCLES  = 40;
  localparam string OVF_MARKER     = "!--overflow--!";

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_FLOOD} phase_t;

  // one predicted result beat
  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_enable;
    logic       overflow;
    logic [5:0] fill_level;
  } tx_expect_t;

  // ring shadow and queue of predicted beats
  class tx_queue_scoreboard;
    logic [7:0] slot_q [QUEUE_DEPTH];
    int         wr_slot;
    int         rd_slot;
    bit         irq_on;
    tx_expect_t due_q [$];
    int         errors;
    int         sends;
    int         ticks;
    int         overflows;
    int         pops;
    int         checked;

    function bit ring_full();
      return ((wr_slot + 1) % QUEUE_DEPTH) == rd_slot;
    endfunction

    // predict the beat caused by one accepted input
    function void note_input(cmd_t cmd, logic [7:0] data);
      tx_expect_t nxt;
      nxt = '{tx_valid: 1'b0, tx_byte: 8'h00, irq_enable: 1'b0, overflow: 1'b0,
              fill_level: 6'd0};
      if (cmd == CMD_SEND) begin
        sends++;
        if (ring_full()) begin
          // flush pending bytes, queue the marker, drop the new byte
          wr_slot = rd_slot;
          for (int i = 0; i < OVF_MARKER.len(); i++) begin
            slot_q[wr_slot] = OVF_MARKER[i];
            if (!ring_full())
              wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
          end
          nxt.overflow = 1'b1;
          overflows++;
        end else begin
          slot_q[wr_slot] = data;
          wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
        end
        irq_on = 1'b1;
      end else begin
        ticks++;
        if (wr_slot != rd_slot) begin
          nxt.tx_valid = 1'b1;
          nxt.tx_byte  = slot_q[rd_slot];
          rd_slot      = (rd_slot + 1) % QUEUE_DEPTH;
          pops++;
        end else begin
          // empty ring on a tick turns the interrupt off
          irq_on = 1'b0;
        end
      end
      nxt.irq_enable = irq_on;
      nxt.fill_level = 6'((wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH);
      due_q.push_back(nxt);
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void check_result(logic user, logic [15:0] data);
      tx_expect_t due;
      if (due_q.size() == 0) begin
        $error("result beat with no prediction waiting: tuser %0h tdata %04h", user, data);
        errors++;
        return;
      end
      due = due_q.pop_front();
      checked++;
      if (user !== due.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", due.tx_valid, user);
        errors++;
      end
      if (data[7:0] !== due.tx_byte) begin
        $error("tx_byte: expected %02h, got %02h", due.tx_byte, data[7:0]);
        errors++;
      end
      if (data[8] !== due.irq_enable) begin
        $error("irq_enable: expected %0d, got %0d", due.irq_enable, data[8]);
        errors++;
      end
      if (data[9] !== due.overflow) begin
        $error("overflow: expected %0d, got %0d", due.overflow, data[9]);
        errors++;
      end
      if (data[15:10] !== due.fill_level) begin
        $error("fill_level: expected %0d, got %0d", due.fill_level, data[15:10]);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_tuser  = 1'b0;    // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] tx_byte, [8] irq_enable, [9] overflow,
                                   // [15:10] fill_level
  logic        m_tuser;            // [0] tx_valid

  tx_queue_scoreboard sb = new();
  int items_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;
  bit rx_hold_req = 1'b0;

  tx_ring_buffer_overflow_marker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // input beat monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_input(cmd_t'(s_tuser), s_tdata);
  end

  // result beat monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata);
  end

  // receiver: random back-pressure bursts plus one long hold-off on request
  initial begin
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one beat and hold it until accepted
  task automatic drive_item(cmd_t cmd, logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic wait_queue_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    phase_t     phase;
    int         phase_len;
    int         send_pct;
    int         phase_no;
    bit         calm;
    bit         hold_done;
    cmd_t       cmd;
    logic [7:0] data;

    phase_no  = 0;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tick on empty ring, extreme bytes, pop to empty, enable clearing
    drive_item(CMD_TICK, 8'hFF);
    drive_item(CMD_SEND, 8'h00);
    drive_item(CMD_SEND, 8'hFF);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_TICK, 8'hA5);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_SEND, 8'h55);
    drive_item(CMD_SEND, 8'hAA);
    drive_item(CMD_SEND, 8'h01);
    drive_item(CMD_SEND, 8'h80);
    drive_item(CMD_TICK, 8'hFF);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_TICK, 8'h00);
    drive_item(CMD_SEND, 8'h7F);
    drive_item(CMD_TICK, 8'h00);

    // random phases; the first one floods the ring into an overflow
    while (items_sent < ITEM_TOTAL) begin
      if (phase_no == 0) begin
        phase     = PH_FLOOD;
        phase_len = 80;
      end else begin
        phase     = phase_t'($urandom_range(0, 3));
        phase_len = $urandom_range(20, 120);
      end
      case (phase)
        PH_FILL:  send_pct = 90;
        PH_DRAIN: send_pct = 15;
        PH_MIXED: send_pct = 50;
        default:  send_pct = 100;
      endcase
      calm = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < phase_len && items_sent < ITEM_TOTAL; i++) begin
        cmd  = ($urandom_range(0, 99) < send_pct) ? CMD_SEND : CMD_TICK;
        data = 8'($urandom_range(0, 255));
        drive_item(cmd, data);
        quiet = (items_sent >= ITEM_TOTAL - QUIET_TAIL);

        // long receiver hold-off while beats keep coming
        if (!hold_done && items_sent >= 700) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end

        if (!quiet && !calm && !rx_hold_req && $urandom_range(0, 4) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end

      // sender pause until the block has answered everything
      if (!quiet && phase_no % 5 == 2)
        wait_queue_drained();
      phase_no++;
    end

    wait_queue_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d sends with %0d overflows and %0d ticks with %0d pops",
             sb.sends, sb.overflows, sb.ticks, sb.pops);
    $display("%0d result beats checked over %0d phases", sb.checked, phase_no);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
